[rtl/a2d_pkg.sv]
// ----------------------------------------------------------------------------
// a2d_pkg
// Shared types, widths and calibration table of the ADC-to-distance
// interpolator.
// ----------------------------------------------------------------------------
package a2d_pkg;

    // Field widths
    localparam int X_W = 12;            // converter reading
    localparam int Y_W = 14;            // distance, unsigned Q8
    localparam int P_W = X_W + Y_W;     // product of |y1 - y0| and offset
    localparam int Q_W = Y_W;           // correction quotient never exceeds |y1 - y0|

    // Calibration table
    localparam int TABLE_POINTS = 10;
    localparam int LAST_IDX     = TABLE_POINTS - 1;
    localparam int IDX_W        = $clog2(TABLE_POINTS);

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = ((X_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((Y_W + 7) / 8) * 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Calibration readings, descending; entries past the tenth read zero
    function automatic logic [X_W-1:0] cal_x(input int idx);
        logic [X_W-1:0] v;
        case (idx)
            0:       v = X_W'(3200);
            1:       v = X_W'(2700);
            2:       v = X_W'(2200);
            3:       v = X_W'(1850);
            4:       v = X_W'(1550);
            5:       v = X_W'(1300);
            6:       v = X_W'(1100);
            7:       v = X_W'(950);
            8:       v = X_W'(820);
            9:       v = X_W'(720);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Calibration distances in Q8 (9 cm .. 50 cm)
    function automatic logic [Y_W-1:0] cal_y(input int idx);
        logic [Y_W-1:0] v;
        case (idx)
            0:       v = Y_W'(2304);
            1:       v = Y_W'(3072);
            2:       v = Y_W'(3840);
            3:       v = Y_W'(5120);
            4:       v = Y_W'(6400);
            5:       v = Y_W'(7680);
            6:       v = Y_W'(8960);
            7:       v = Y_W'(10240);
            8:       v = Y_W'(11520);
            9:       v = Y_W'(12800);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Classified job handed from front to back
    typedef struct packed {
        logic           clamped;  // reading at or past a table end
        logic           bypass;   // result is y0 as is, no interpolation
        logic           neg;      // distance falls across the segment
        logic [Y_W-1:0] y0;       // segment start distance
        logic [Y_W-1:0] dy;       // |y1 - y0|
        logic [X_W-1:0] off;      // x0 - x
        logic [X_W-1:0] den;      // x0 - x1
    } job_t;

endpackage

[rtl/a2d_front.sv]
// ----------------------------------------------------------------------------
// a2d_front
// Accepts readings, clamps the ends and picks the bracketing segment.
// One registered stage; emits one job per reading.
// ----------------------------------------------------------------------------
module a2d_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [a2d_pkg::S_DATA_W-1:0] s_tdata,    // [11:0] adc_value
    output logic                         job_valid,
    input  logic                         job_ready,
    output a2d_pkg::job_t                job
);

    logic [a2d_pkg::X_W-1:0]   x;
    logic [a2d_pkg::IDX_W-1:0] seg_idx;
    logic                      seg_hit;
    logic [a2d_pkg::X_W-1:0]   x0;
    logic [a2d_pkg::X_W-1:0]   x1;
    logic [a2d_pkg::Y_W-1:0]   y0;
    logic [a2d_pkg::Y_W-1:0]   y1;
    a2d_pkg::job_t             job_next;
    a2d_pkg::job_t             job_reg;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      load;

    assign x = s_tdata[a2d_pkg::X_W-1:0];

    // First bracketing segment: scan from the top, last match (lowest index) wins
    always_comb
    begin
        seg_idx = '0;
        seg_hit = 1'b0;
        for (int i = a2d_pkg::TABLE_POINTS - 2; i >= 0; i--)
        begin
            if (x <= a2d_pkg::cal_x(i) && x >= a2d_pkg::cal_x(i + 1))
            begin
                seg_idx = a2d_pkg::IDX_W'(i);
                seg_hit = 1'b1;
            end
        end
    end

    // Segment end points
    assign x0 = a2d_pkg::cal_x(int'(seg_idx));
    assign x1 = a2d_pkg::cal_x(int'(seg_idx) + 1);
    assign y0 = a2d_pkg::cal_y(int'(seg_idx));
    assign y1 = a2d_pkg::cal_y(int'(seg_idx) + 1);

    // Classification
    always_comb
    begin
        job_next.clamped = 1'b0;
        job_next.bypass  = 1'b1;
        job_next.neg     = (y1 < y0);
        job_next.y0      = a2d_pkg::cal_y(a2d_pkg::LAST_IDX);
        job_next.dy      = (y1 < y0) ? (y0 - y1) : (y1 - y0);
        job_next.off     = x0 - x;
        job_next.den     = x0 - x1;
        if (x >= a2d_pkg::cal_x(0))
        begin
            job_next.clamped = 1'b1;
            job_next.y0      = a2d_pkg::cal_y(0);
        end
        else if (x <= a2d_pkg::cal_x(a2d_pkg::LAST_IDX))
        begin
            job_next.clamped = 1'b1;
        end
        else if (seg_hit)
        begin
            // zero-width segment yields y0
            job_next.y0     = y0;
            job_next.bypass = (job_next.den == '0);
        end
    end

    // Output stage handshake
    assign s_tready   = !valid_reg || job_ready;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (valid_reg && !job_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

[rtl/a2d_queue.sv]
// ----------------------------------------------------------------------------
// a2d_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module a2d_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  a2d_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output a2d_pkg::job_t out_job
);

    a2d_pkg::job_t                mem_reg [a2d_pkg::QUEUE_DEPTH];
    logic [a2d_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [a2d_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [a2d_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [a2d_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [a2d_pkg::QCNT_W-1:0]   count_reg;
    logic [a2d_pkg::QCNT_W-1:0]   count_next;
    logic                         push;
    logic                         pop;

    assign in_ready  = (count_reg != a2d_pkg::QCNT_W'(a2d_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == a2d_pkg::QPTR_W'(a2d_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == a2d_pkg::QPTR_W'(a2d_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    // Fill count stays within the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= a2d_pkg::QCNT_W'(a2d_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

endmodule

[rtl/a2d_back.sv]
// ----------------------------------------------------------------------------
// a2d_back
// Interpolation pipeline: |y1 - y0| times offset, one restoring divide step
// per stage, then add or subtract the correction (bypass passes y0). Output register.
// ----------------------------------------------------------------------------
module a2d_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  a2d_pkg::job_t                job,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [a2d_pkg::M_DATA_W-1:0] m_tdata,    // [13:0] distance_q8
    output logic [0:0]                   m_tuser     // [0] clamped
);

    localparam int NS = a2d_pkg::Q_W + 1;   // multiply stage plus divide steps

    // Pipeline stage registers
    logic                    vld_reg [NS];
    logic [a2d_pkg::P_W-1:0] rem_reg [NS];
    logic [a2d_pkg::Q_W-1:0] quo_reg [NS];
    logic [a2d_pkg::X_W-1:0] den_reg [NS];
    logic [a2d_pkg::Y_W-1:0] y0_reg  [NS];
    logic                    neg_reg [NS];
    logic                    byp_reg [NS];
    logic                    clp_reg [NS];

    logic                    out_valid_reg;
    logic [a2d_pkg::Y_W-1:0] dist_reg;
    logic [a2d_pkg::Y_W-1:0] dist_next;
    logic                    clamp_reg;
    logic                    adv;

    // Whole pipeline moves unless a finished result is held
    assign adv       = !(out_valid_reg && !m_tready);
    assign job_ready = adv;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= a2d_pkg::P_W'(job.dy) * a2d_pkg::P_W'(job.off);
            quo_reg[0] <= '0;
            den_reg[0] <= job.den;
            y0_reg[0]  <= job.y0;
            neg_reg[0] <= job.neg;
            byp_reg[0] <= job.bypass;
            clp_reg[0] <= job.clamped;
        end
    end

    // Divide steps, most significant quotient bit first
    for (genvar k = 0; k < a2d_pkg::Q_W; k++)
    begin : g_div
        localparam int B = a2d_pkg::Q_W - 1 - k;
        logic [a2d_pkg::P_W-1:0] trial;
        logic                    fits;

        assign trial = a2d_pkg::P_W'(den_reg[k]) << B;
        assign fits  = (rem_reg[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= fits ? (rem_reg[k] - trial) : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (a2d_pkg::Q_W'(fits) << B);
                den_reg[k+1] <= den_reg[k];
                y0_reg[k+1]  <= y0_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                byp_reg[k+1] <= byp_reg[k];
                clp_reg[k+1] <= clp_reg[k];
            end
        end
    end

    // Apply the correction; wraps to the field width
    always_comb
    begin
        if (byp_reg[NS-1])
        begin
            dist_next = y0_reg[NS-1];
        end
        else if (neg_reg[NS-1])
        begin
            dist_next = y0_reg[NS-1] - quo_reg[NS-1];
        end
        else
        begin
            dist_next = y0_reg[NS-1] + quo_reg[NS-1];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg  <= dist_next;
            clamp_reg <= clp_reg[NS-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = a2d_pkg::M_DATA_W'(dist_reg);
    assign m_tuser  = clamp_reg;

    // Division finished: remainder below the divisor
    a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && !byp_reg[NS-1]) |-> (rem_reg[NS-1] < a2d_pkg::P_W'(den_reg[NS-1])))
        else $error("divide remainder not reduced");

    // Clamped results sit on a table end
    a_clamp_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && clamp_reg) |->
            (dist_reg == a2d_pkg::cal_y(0) || dist_reg == a2d_pkg::cal_y(a2d_pkg::LAST_IDX)))
        else $error("clamped distance not a table end");

    // A held result freezes the pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vld_reg[NS-1]) && $stable(dist_reg)))
        else $error("pipeline moved during stall");

endmodule

[rtl/adc_to_distance_interpolator.sv]
// ----------------------------------------------------------------------------
// adc_to_distance_interpolator
// Converts a 12-bit sensor reading to a distance in cm (unsigned Q8) by
// piecewise linear interpolation over a ten-point calibration table.
// ----------------------------------------------------------------------------
// Takes one reading per clock while the output is not stalled, and
// returns one result per reading, in order. A reading passes through one
// classify stage, the two-entry job queue, one multiply stage, fourteen
// divide stages (one quotient bit each) and the output register. A
// reading at or past either table end is clamped to that end's distance
// and flagged in m_tuser. Results truncate toward zero.
module adc_to_distance_interpolator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [a2d_pkg::S_DATA_W-1:0] s_tdata,    // [11:0] adc_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [a2d_pkg::M_DATA_W-1:0] m_tdata,    // [13:0] distance_q8
    output logic [0:0]                   m_tuser     // [0] clamped
);

    logic          fj_valid;
    logic          fj_ready;
    a2d_pkg::job_t fj;
    logic          bj_valid;
    logic          bj_ready;
    a2d_pkg::job_t bj;

    // Front: clamp and segment select
    a2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    // Job queue
    a2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_job    (fj),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_job   (bj)
    );

    // Back: interpolation pipeline
    a2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[tb/sv/tb_adc_to_distance_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_to_distance_interpolator
// Self-checking bench for the ADC-to-distance interpolator. A directed set
// of readings (table ends, every calibration point, both sides of each end,
// alternating bit patterns) is followed by random readings, mostly inside
// the table span. Each accepted reading is converted by a local piecewise
// linear model of the calibration curve, and every result transfer is
// checked in order against it. Both stream sides insert random gaps, and
// the sink holds off for long stretches so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb_adc_to_distance_interpolator;

    localparam int X_W      = a2d_pkg::X_W;
    localparam int Y_W      = a2d_pkg::Y_W;
    localparam int S_DATA_W = a2d_pkg::S_DATA_W;
    localparam int M_DATA_W = a2d_pkg::M_DATA_W;

    localparam int CAL_POINTS     = 10;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int BACKLOG_CYCLES = 300;
    localparam int MAX_REPORTS    = 50;

    // Calibration curve: readings descending, distances in Q8
    localparam int unsigned CAL_READING [CAL_POINTS] =
        '{3200, 2700, 2200, 1850, 1550, 1300, 1100, 950, 820, 720};
    localparam int unsigned CAL_DIST_Q8 [CAL_POINTS] =
        '{2304, 3072, 3840, 5120, 6400, 7680, 8960, 10240, 11520, 12800};

    typedef struct packed {
        logic [Y_W-1:0] distance_q8;
        logic           clamped;
    } distance_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    logic [X_W-1:0]      pending_readings [$];
    distance_result_t    expected_distances [$];

    logic                reading_taken   = 1'b0;
    int                  readings_taken  = 0;
    int                  results_seen    = 0;
    int                  error_count     = 0;
    int                  cycle_count     = 0;

    adc_to_distance_interpolator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [11:0] adc_value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [13:0] distance_q8
        .m_tuser  (m_tuser)     // [0] clamped
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Expected distance for one reading
    function automatic distance_result_t convert_reading(input logic [X_W-1:0] reading);
        distance_result_t  res;
        longint unsigned   x;
        longint unsigned   x0;
        longint unsigned   x1;
        longint unsigned   y0;
        longint unsigned   y1;
        longint unsigned   dist_q8;
        bit                found;
        x       = reading;
        dist_q8 = CAL_DIST_Q8[CAL_POINTS-1];
        found   = 1'b0;
        res.clamped = 1'b0;
        if (x >= CAL_READING[0])
        begin
            dist_q8 = CAL_DIST_Q8[0];
            res.clamped = 1'b1;
        end
        else if (x <= CAL_READING[CAL_POINTS-1])
        begin
            dist_q8 = CAL_DIST_Q8[CAL_POINTS-1];
            res.clamped = 1'b1;
        end
        else
        begin
            for (int i = 0; i < CAL_POINTS - 1; i++)
            begin
                x0 = CAL_READING[i];
                x1 = CAL_READING[i+1];
                y0 = CAL_DIST_Q8[i];
                y1 = CAL_DIST_Q8[i+1];
                if (!found && x <= x0 && x >= x1)
                begin
                    found = 1'b1;
                    // zero-width segment keeps the start distance
                    if (x0 == x1)
                        dist_q8 = y0;
                    else if (y1 >= y0)
                        dist_q8 = y0 + ((y1 - y0) * (x0 - x)) / (x0 - x1);
                    else
                        dist_q8 = y0 - ((y0 - y1) * (x0 - x)) / (x0 - x1);
                end
            end
        end
        res.distance_q8 = dist_q8[Y_W-1:0];
        return res;
    endfunction

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Source side: offer queued readings with random gaps
    int src_gap_left  = 0;
    int src_calm_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || reading_taken)
        begin
            if (src_gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                src_gap_left--;
            end
            else if (pending_readings.size() != 0)
            begin
                s_tdata  <= S_DATA_W'(pending_readings.pop_front());
                s_tvalid <= 1'b1;
                if (src_calm_left > 0)
                    src_calm_left--;
                else if ($urandom_range(0, 99) < 2)
                    src_calm_left = $urandom_range(50, 150);
                else if ($urandom_range(0, 1) == 0)
                    src_gap_left = pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, calm stretches and two long backlogs
    int snk_stall_left   = 0;
    int snk_calm_left    = 0;
    int backlogs_done    = 0;
    int next_backlog_at  = 200;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (backlogs_done < 2 && readings_taken >= next_backlog_at)
            begin
                snk_stall_left  = BACKLOG_CYCLES;
                snk_calm_left   = 0;
                backlogs_done++;
                next_backlog_at = next_backlog_at + 800;
            end
            if (snk_stall_left > 0)
            begin
                m_tready <= 1'b0;
                snk_stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (snk_calm_left > 0)
                    snk_calm_left--;
                else if ($urandom_range(0, 99) < 2)
                    snk_calm_left = $urandom_range(50, 200);
                else if ($urandom_range(0, 3) == 0)
                    snk_stall_left = pick_gap();
            end
        end
    end

    // Monitor: check result transfers, then record input transfers
    always @(posedge clk)
    begin
        distance_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_distances.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, distance %0d clamped %0b",
                                 $time, m_tdata[Y_W-1:0], m_tuser[0]);
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (m_tdata[Y_W-1:0] !== want.distance_q8)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: result %0d distance: expected %0d, actual %0d",
                                     $time, results_seen, want.distance_q8,
                                     m_tdata[Y_W-1:0]);
                    end
                    if (m_tuser[0] !== want.clamped)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: result %0d clamped: expected %0b, actual %0b",
                                     $time, results_seen, want.clamped, m_tuser[0]);
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                expected_distances.push_back(convert_reading(s_tdata[X_W-1:0]));
                readings_taken++;
            end
            reading_taken <= s_tvalid && s_tready;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int r;
        int pt;

        // table ends, both sides of each end, bit patterns
        pending_readings.push_back(X_W'(0));
        pending_readings.push_back(X_W'(4095));
        pending_readings.push_back(X_W'(3200));
        pending_readings.push_back(X_W'(3199));
        pending_readings.push_back(X_W'(3201));
        pending_readings.push_back(X_W'(720));
        pending_readings.push_back(X_W'(721));
        pending_readings.push_back(X_W'(719));
        pending_readings.push_back(X_W'('hAAA));
        pending_readings.push_back(X_W'('h555));
        // interior readings equal to a calibration point
        for (int i = 1; i < CAL_POINTS - 1; i++)
            pending_readings.push_back(X_W'(CAL_READING[i]));
        // one below 2700 and 820, one above 1300, the midpoint of 3200..2700
        pending_readings.push_back(X_W'(2699));
        pending_readings.push_back(X_W'(1301));
        pending_readings.push_back(X_W'(2950));
        pending_readings.push_back(X_W'(819));

        // random readings, weighted toward the table span
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                pending_readings.push_back(X_W'($urandom_range(721, 3199)));
            end
            else if (r < 80)
            begin
                pt = $urandom_range(0, CAL_POINTS - 1);
                pending_readings.push_back(
                    X_W'(int'(CAL_READING[pt]) + $urandom_range(0, 6) - 3));
            end
            else
            begin
                pending_readings.push_back(X_W'($urandom_range(0, 4095)));
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all readings to go in and all results to come out
        @(negedge clk);
        while (pending_readings.size() != 0 || s_tvalid || expected_distances.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[adc_to_distance_interpolator.f]
rtl/a2d_pkg.sv
rtl/a2d_front.sv
rtl/a2d_queue.sv
rtl/a2d_back.sv
rtl/adc_to_distance_interpolator.sv
tb/sv/tb_adc_to_distance_interpolator.sv
